[hdl/ght_pkg.sv]
package ght_pkg;

  // Default sizing of the table.
  localparam int unsigned DefSlots      = 256;
  localparam int unsigned DefGenBits    = 16;
  localparam int unsigned DefRecordBits = 32;

  // Request kinds.
  localparam logic [1:0] MODE_CREATE  = 2'd0;
  localparam logic [1:0] MODE_LOOKUP  = 2'd1;
  localparam logic [1:0] MODE_DESTROY = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_STALE   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

endpackage

[hdl/generational_handle_table.sv]
// Flow: a request beat is registered with its memory reads; a create that reuses an id from
// the free stack first passes S_POP (one extra memory read for the pop), then S_EXEC commits
// the result into the output register once it is free. A new request is taken only in S_IDLE,
// after the previous one has committed; a full output register stalls that commit.
// Reset (rst_ni low, asynchronous) empties the table at once: no clearing pass is run.
module generational_handle_table
  import ght_pkg::*;
#(
  parameter int unsigned SLOTS       = DefSlots,
  parameter int unsigned GEN_BITS    = DefGenBits,
  parameter int unsigned RECORD_BITS = DefRecordBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   mode_i,
  input  logic [$clog2(SLOTS+1)-1:0]   handle_id_i,
  input  logic [GEN_BITS-1:0]          handle_gen_i,
  input  logic [RECORD_BITS-1:0]       record_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [$clog2(SLOTS+1)-1:0]   out_id_o,
  output logic [GEN_BITS-1:0]          out_gen_o,
  output logic [RECORD_BITS-1:0]       record_out_o,
  output logic [$clog2(SLOTS+1)-1:0]   live_total_o
);

  // Ids are one-based and can reach SLOTS itself, so they carry one bit more than
  // a memory address in the power-of-two case.
  localparam int unsigned IdW = $clog2(SLOTS + 1);
  localparam int unsigned AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdW-1:0] SlotsId = IdW'(SLOTS);

  // Sequencer codes.
  localparam logic [1:0] S_IDLE = 2'd0;  // ready for a request beat
  localparam logic [1:0] S_POP  = 2'd1;  // free stack data arrives, slot read issued
  localparam logic [1:0] S_EXEC = 2'd2;  // slot data arrives, commit and report

  // One slot memory word holds everything about a slot.
  typedef struct packed {
    logic                   alive;
    logic [GEN_BITS-1:0]    gen;
    logic [RECORD_BITS-1:0] rec;
  } slot_t;

  // Storage. Neither memory is reset. The table is filled from the bottom: slots
  // above the fill count used_q were never handed out, so their read data is never used.
  // A fresh create takes the reset view of its slot (dead, generation one) directly,
  // and every id on the free stack was written by the destroy that pushed it.
  slot_t          slot_mem [SLOTS];
  logic [IdW-1:0] stack_mem [SLOTS];

  slot_t          slot_rdata_q;
  logic [IdW-1:0] stack_rdata_q;

  logic [1:0]             state_q, state_d;
  logic [1:0]             mode_q;
  logic [IdW-1:0]         hid_q;
  logic [GEN_BITS-1:0]    hgen_q;
  logic [RECORD_BITS-1:0] rec_q;
  logic                   pop_q;
  logic [IdW-1:0]         pop_id_q;

  logic [IdW-1:0] free_top_q, free_top_d;
  logic [IdW-1:0] used_q, used_d;
  logic [IdW-1:0] live_q, live_d;

  // Output register: it lets the next request in while a result beat waits.
  logic                   out_valid_q;
  logic [1:0]             status_q;
  logic [IdW-1:0]         out_id_q;
  logic [GEN_BITS-1:0]    out_gen_q;
  logic [RECORD_BITS-1:0] out_rec_q;
  logic [IdW-1:0]         out_live_q;

  logic in_fire;
  logic out_free;
  logic commit;

  logic           slot_re;
  logic [AW-1:0]  slot_raddr;
  logic           slot_we;
  logic [AW-1:0]  slot_waddr;
  slot_t          slot_wdata;
  logic           stack_re;
  logic [AW-1:0]  stack_raddr;
  logic           stack_we;
  logic [IdW-1:0] rd_id_m1;
  logic [IdW-1:0] pop_id_m1;
  logic [IdW-1:0] top_m1;

  logic [1:0]             res_status;
  logic [IdW-1:0]         res_id;
  logic [GEN_BITS-1:0]    res_gen;
  logic [RECORD_BITS-1:0] res_rec;
  logic [IdW-1:0]         new_id;
  logic [IdW-1:0]         new_id_m1;
  logic [IdW-1:0]         hid_m1;
  logic [GEN_BITS-1:0]    new_gen;
  logic                   new_alive;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  // The commit waits in S_EXEC until the output register can take the result;
  // the read data registers hold meanwhile because no new read is issued.
  assign commit     = (state_q == S_EXEC) && out_free;

  // Read side. A create with a nonempty free stack first reads the stack top,
  // then the slot of the popped id. Lookup and destroy read their slot at once;
  // an out-of-range id reads a word that is never used.
  assign rd_id_m1    = handle_id_i - IdW'(1);
  assign pop_id_m1   = stack_rdata_q - IdW'(1);
  assign top_m1      = free_top_q - IdW'(1);
  assign stack_re    = in_fire;
  assign stack_raddr = top_m1[AW-1:0];
  assign slot_re     = in_fire || (state_q == S_POP);
  assign slot_raddr  = (state_q == S_POP) ? pop_id_m1[AW-1:0] : rd_id_m1[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rdata_q <= slot_mem[slot_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[free_top_q[AW-1:0]] <= hid_q;
    end
    if (stack_re) begin
      stack_rdata_q <= stack_mem[stack_raddr];
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (mode_i == MODE_CREATE && free_top_q != '0) ? S_POP : S_EXEC;
        end
      end
      S_POP: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Execute: decide the result and the writes from the request and the slot word.
  assign hid_m1    = hid_q - IdW'(1);
  assign new_id    = pop_q ? pop_id_q : (used_q + IdW'(1));
  assign new_id_m1 = new_id - IdW'(1);
  assign new_gen   = pop_q ? slot_rdata_q.gen : GEN_BITS'(1);
  assign new_alive = pop_q && slot_rdata_q.alive;

  always_comb begin
    res_status = ST_OK;
    res_id     = '0;
    res_gen    = '0;
    res_rec    = '0;
    slot_we    = 1'b0;
    slot_waddr = new_id_m1[AW-1:0];
    slot_wdata = '{alive: 1'b1, gen: new_gen, rec: rec_q};
    stack_we   = 1'b0;
    free_top_d = free_top_q;
    used_d     = used_q;
    live_d     = live_q;
    unique case (mode_q)
      MODE_CREATE: begin
        if (pop_q || used_q != SlotsId) begin
          res_id  = new_id;
          res_gen = new_gen;
          slot_we = commit;
          if (pop_q) begin
            free_top_d = top_m1;
          end else begin
            used_d = used_q + IdW'(1);
          end
          if (!new_alive) begin
            live_d = live_q + IdW'(1);
          end
        end else begin
          res_status = ST_FULL;
        end
      end
      MODE_LOOKUP, MODE_DESTROY: begin
        if (hid_q == '0 || hid_q > used_q) begin
          res_status = ST_UNKNOWN;
        end else if (!slot_rdata_q.alive || slot_rdata_q.gen != hgen_q) begin
          res_status = ST_STALE;
          res_id     = hid_q;
        end else begin
          res_id = hid_q;
          if (mode_q == MODE_LOOKUP) begin
            res_gen = slot_rdata_q.gen;
            res_rec = slot_rdata_q.rec;
          end else begin
            // Kill the slot, bump its generation (wrapping) and push the id.
            res_gen    = slot_rdata_q.gen + GEN_BITS'(1);
            slot_we    = commit;
            slot_waddr = hid_m1[AW-1:0];
            slot_wdata = '{alive: 1'b0, gen: res_gen, rec: '0};
            if (free_top_q != SlotsId) begin
              stack_we   = commit;
              free_top_d = free_top_q + IdW'(1);
            end
            if (live_q != '0) begin
              live_d = live_q - IdW'(1);
            end
          end
        end
      end
      default: begin
        // Unused kind: nothing changes, an ok result with zero id, generation and record goes out.
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_top_q  <= '0;
      used_q      <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
      pop_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        pop_q <= (mode_i == MODE_CREATE) && (free_top_q != '0);
      end
      if (commit) begin
        free_top_q  <= free_top_d;
        used_q      <= used_d;
        live_q      <= live_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= mode_i;
      hid_q  <= handle_id_i;
      hgen_q <= handle_gen_i;
      rec_q  <= record_in_i;
    end
    if (state_q == S_POP) begin
      pop_id_q <= stack_rdata_q;
    end
    if (commit) begin
      status_q   <= res_status;
      out_id_q   <= res_id;
      out_gen_q  <= res_gen;
      out_rec_q  <= res_rec;
      out_live_q <= live_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign out_id_o     = out_id_q;
  assign out_gen_o    = out_gen_q;
  assign record_out_o = out_rec_q;
  assign live_total_o = out_live_q;

`ifndef ASSERT_OFF
  // Every id handed out is either alive or waiting on the free stack.
  a_id_conservation: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, free_top_q} + {1'b0, live_q}) == {1'b0, used_q})
    else $error("free ids plus live ids differ from ids handed out");

  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= used_q)
    else $error("live count above fill count");

  // A full table has every slot alive.
  a_full_means_all_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> live_total_o == SlotsId)
    else $error("table full reported with a dead slot");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |-> free_top_q != '0)
    else $error("pop from an empty free stack");
`endif

endmodule
